// ----- rtl/core/isc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants of the itemset support counter.
// ----------------------------------------------------------------------------
package isc_pkg;

	// field widths
	localparam int ROWS_W   = 11;
	localparam int ITEMS_W  = 7;
	localparam int INDEX_W  = 10;
	localparam int WORD_W   = 64;
	localparam int FRAC_W   = 17;
	localparam int STAT_W   = 2;
	localparam int CFG_W    = 11;
	localparam int DIVCNT_W = 5;

	// last step of the 17-step quotient loop
	localparam logic [DIVCNT_W-1:0] DIV_LAST = 5'd16;

	// operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_WIDTH = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// register indexes
	localparam logic REG_ROWS  = 1'b0;
	localparam logic REG_ITEMS = 1'b1;

	localparam logic [ITEMS_W-1:0] ITEMS_RESET = 7'd64;

	typedef struct packed {
		logic               operation;
		logic [INDEX_W-1:0] row_index;
		logic [WORD_W-1:0]  row_bits;
		logic [WORD_W-1:0]  query_mask;
		logic [ITEMS_W-1:0] query_width;
	} req_t;

	typedef struct packed {
		logic [ROWS_W-1:0] support_count;
		logic [FRAC_W-1:0] support_fraction;
		logic [STAT_W-1:0] status;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load_wr;
		logic query_start;
		logic scan;
		logic div_step;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic query_bad;
		logic scan_last;
		logic div_last;
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DIVIDE,
		S_DONE
	} state_t;

endpackage

// ----- rtl/core/itemset_support_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itemset_support_counter
// Support counting of an itemset over a store of transaction bit vectors.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. A load
// request writes one row into the transaction store; busy stays low and no
// result follows. A query request holds busy while it scans R rows, where R
// is rows_in_use clamped to MAX_ROWS, through the store's single read port,
// one row a cycle, then drains the registered read, runs the bit-per-step
// restoring divider for the Q1.16 fraction, and in the last busy cycle
// shows the result with done high. A query with a width mismatch or no
// rows in use goes straight to the done state. done lasts exactly one cycle
// and the receiver cannot stall it, so the result must be taken in that
// cycle. The store has no reset; rows read by a query must have been loaded
// first. Configuration must be written only while busy is low; the block
// itself does not enforce this.
module itemset_support_counter import isc_pkg::*; #(
	parameter int MAX_ROWS  = 1024,
	parameter int MAX_ITEMS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	// command channel
	input  logic             start,
	output logic             busy,
	input  req_t             request,
	// result strobe
	output logic             done,
	output res_t             result,
	// configuration writes
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer: decodes start, walks scan, drain, divide and report
	isc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (request.operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	// store, match counter, divider and config registers
	isc_datapath #(
		.MAX_ROWS  (MAX_ROWS),
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.request   (request),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

`ifndef NO_ASSERTIONS
	// result strobe is a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// error results carry zero count and fraction
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |->
			(result.support_count == '0 && result.support_fraction == '0))
		else $error("error result with nonzero payload");

	// fraction never exceeds 1.0
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_OK) |-> (result.support_fraction <= 17'd65536))
		else $error("support fraction above one");

	// a load never makes the block busy
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.operation == OP_LOAD) |=> !busy)
		else $error("load request raised busy");
`endif

endmodule

// ----- rtl/core/isc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_ctrl
// Sequencer for loads, row scan, quotient loop and result strobe.
// ----------------------------------------------------------------------------
module isc_ctrl import isc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  operation,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && operation == OP_QUERY) begin
					state_d = stat.query_bad ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DIVIDE;
			end
			S_DIVIDE: begin
				if (stat.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load_wr     = accept && operation == OP_LOAD;
		cmd.query_start = accept && operation == OP_QUERY;
		cmd.scan        = (state_q == S_SCAN);
		cmd.div_step    = (state_q == S_DIVIDE);
		busy            = (state_q != S_IDLE);
		done            = (state_q == S_DONE);
	end

endmodule

// ----- rtl/core/isc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isc_datapath
// Transaction store, match counter, restoring divider and config registers.
// ----------------------------------------------------------------------------
module isc_datapath import isc_pkg::*; #(
	parameter int MAX_ROWS  = 1024,
	parameter int MAX_ITEMS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  req_t             request,
	input  cmd_t             cmd,
	output stat_t            stat,
	output res_t             result
);

	localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam logic [16:0] MAX_ROWS_L = 17'(MAX_ROWS);

	// config registers
	logic [ROWS_W-1:0]  rows_cfg_q;
	logic [ITEMS_W-1:0] items_cfg_q;

	// query context
	logic [MAX_ITEMS-1:0] need_q;
	logic [ROWS_W-1:0]    rows_q;
	logic [ROWS_W-1:0]    rows_left_q;
	logic [AW-1:0]        addr_q;
	logic [ROWS_W-1:0]    count_q;
	logic [STAT_W-1:0]    status_q;

	// store and read pipe
	logic [MAX_ITEMS-1:0] mem [MAX_ROWS];
	logic [MAX_ITEMS-1:0] rdata_s1;
	logic                 rd_valid_s1;

	// divider
	logic [DIVCNT_W-1:0] div_cnt_q;
	logic [ROWS_W-1:0]   rem_q;
	logic [FRAC_W-1:0]   quot_q;

	logic [MAX_ITEMS-1:0] col_mask;
	logic [ROWS_W-1:0]    rows_clamp;
	logic                 width_err;
	logic                 rows_empty;
	logic                 wr_ok;
	logic [AW-1:0]        waddr;
	logic [ROWS_W:0]      trial;
	logic                 ge;
	logic [ROWS_W:0]      diff;

	always_comb begin
		for (int j = 0; j < MAX_ITEMS; j++) begin
			col_mask[j] = (7'(j) < items_cfg_q);
		end
	end

	assign rows_clamp = (17'(rows_cfg_q) > MAX_ROWS_L) ? 11'(MAX_ROWS_L) : rows_cfg_q;
	assign width_err  = (request.query_width != items_cfg_q);
	assign rows_empty = (rows_cfg_q == '0);
	assign wr_ok      = (17'(request.row_index) < MAX_ROWS_L);
	assign waddr      = AW'(request.row_index);

	// first step takes the count itself, later steps the shifted remainder
	assign trial = (div_cnt_q == '0) ? {1'b0, count_q} : {rem_q, 1'b0};
	assign ge    = (trial >= {1'b0, rows_q});
	assign diff  = trial - {1'b0, rows_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q  <= '0;
			items_cfg_q <= ITEMS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS:  rows_cfg_q  <= cfg_data;
				REG_ITEMS: items_cfg_q <= cfg_data[ITEMS_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr && wr_ok) begin
			mem[waddr] <= request.row_bits[MAX_ITEMS-1:0];
		end
		if (cmd.scan) begin
			rdata_s1 <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.query_start) begin
			need_q      <= request.query_mask[MAX_ITEMS-1:0] & col_mask;
			rows_q      <= rows_clamp;
			rows_left_q <= rows_clamp;
			addr_q      <= '0;
			count_q     <= '0;
			div_cnt_q   <= '0;
			quot_q      <= '0;
			if (width_err) begin
				status_q <= STAT_WIDTH;
			end else if (rows_empty) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_OK;
			end
		end else begin
			if (cmd.scan) begin
				addr_q      <= addr_q + 1'b1;
				rows_left_q <= rows_left_q - 1'b1;
			end
			if (rd_valid_s1 && ((rdata_s1 & need_q) == need_q)) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + 1'b1;
				rem_q     <= ge ? diff[ROWS_W-1:0] : trial[ROWS_W-1:0];
				quot_q    <= {quot_q[FRAC_W-2:0], ge};
			end
		end
	end

	assign stat.query_bad = width_err || rows_empty;
	assign stat.scan_last = (rows_left_q == 11'd1);
	assign stat.div_last  = (div_cnt_q == DIV_LAST);

	assign result.support_count    = count_q;
	assign result.support_fraction = quot_q;
	assign result.status           = status_q;

endmodule
